@@ design/fat12_geometry_from_size_macros.svh @@
// Assertion macros shared by the geometry block.
// Each macro takes a label, a condition and an expectation, and reports by $error.
`ifndef FAT12_GEOMETRY_FROM_SIZE_MACROS_SVH
`define FAT12_GEOMETRY_FROM_SIZE_MACROS_SVH

// The expectation holds in the same cycle as the condition.
`define FAT12_ASSERT_NOW(label, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |-> (expect_expr)) else $error(msg);

// The expectation holds in the cycle after the condition.
`define FAT12_ASSERT_NEXT(label, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |=> (expect_expr)) else $error(msg);

`endif

@@ design/fat12_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fat12_pkg;

  localparam logic [22:0] BIG_VOLUME_SECTORS = 23'd8192;
  localparam logic [22:0] MID_VOLUME_SECTORS = 23'd1024;
  localparam logic [31:0] LARGE_ROOT_BYTES   = 32'h0008_C000;
  localparam logic [9:0]  SMALL_ROOT_ENTRIES = 10'd32;
  localparam logic [9:0]  LARGE_ROOT_ENTRIES = 10'd512;
  localparam logic [22:0] SECTOR_ROUND       = 23'd511;

  localparam logic [3:0]  CLUSTER_ONE   = 4'd1;
  localparam logic [3:0]  CLUSTER_FOUR  = 4'd4;
  localparam logic [3:0]  CLUSTER_EIGHT = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M1,
    ST_C1,
    ST_C2,
    ST_CF,
    ST_CLU,
    ST_FAT
  } state_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [15:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

@@ design/fat12_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fat12_mul (
  input  wire logic              clk,
  input  wire fat12_pkg::mul_req_t req,
  output logic [23:0]            prod_r
);
  import fat12_pkg::*;

  logic [23:0] prod_nxt;

  // Shared 8x16 multiplier; the product is registered every cycle.
  assign prod_nxt = {16'd0, req.a} * {8'd0, req.b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

@@ design/fat12_clu.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fat12_clu (
  input  wire logic [22:0] count,
  output logic [3:0]       per_cluster,
  output logic [20:0]      half_clusters
);
  import fat12_pkg::*;

  logic [23:0] sum8;
  logic [23:0] sum4;
  logic [20:0] clusters;
  logic [21:0] half_sum;

  assign sum8 = {1'b0, count} + 24'd7;
  assign sum4 = {1'b0, count} + 24'd3;

  always_comb begin
    if (count > BIG_VOLUME_SECTORS) begin
      per_cluster = CLUSTER_EIGHT;
      clusters    = sum8[23:3];
    end else if (count > MID_VOLUME_SECTORS) begin
      per_cluster = CLUSTER_FOUR;
      clusters    = sum4[22:2];
    end else begin
      per_cluster = CLUSTER_ONE;
      clusters    = count[20:0];
    end
  end

  // Two 12-bit entries share three bytes, so round the cluster count up to pairs.
  assign half_sum      = {1'b0, clusters} + 22'd1;
  assign half_clusters = half_sum[21:1];

endmodule
`default_nettype wire

@@ design/fat12_geometry_from_size.sv @@
// Each geometry growth step runs through states M1, C1 and C2, and a beat ends
// with the CF, CLU and FAT states; a beat takes at most 202 growth steps.
// Only one beat is in flight at a time; the shared multiplier's search loop sets the rate.
// A finished result waits in the output register while the next beat is accepted.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
`include "fat12_geometry_from_size_macros.svh"
module fat12_geometry_from_size (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_image_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [22:0]      out_total_sectors,
  output logic [7:0]       out_track_sectors,
  output logic [7:0]       out_head_count,
  output logic [3:0]       out_cluster_sectors,
  output logic [12:0]      out_table_sectors,
  output logic [9:0]       out_root_dir_entries
);
  import fat12_pkg::*;

  // Sequencer state and the running geometry.
  state_t      state_r, state_nxt;
  logic [22:0] limit_r, limit_nxt;
  logic        small_root_r, small_root_nxt;
  logic [7:0]  spt_r, spt_nxt;
  logic [7:0]  h_r, h_nxt;
  logic [15:0] hsq_r, hsq_nxt;   // h_r squared
  logic [15:0] sq_r, sq_nxt;     // (h_r + 1) squared while a head step is tried
  logic [22:0] count_r, count_nxt;
  logic [3:0]  per_r, per_nxt;
  logic [20:0] half_r, half_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [22:0] o_total_r, o_total_nxt;
  logic [7:0]  o_spt_r, o_spt_nxt;
  logic [7:0]  o_heads_r, o_heads_nxt;
  logic [3:0]  o_per_r, o_per_nxt;
  logic [12:0] o_fat_r, o_fat_nxt;
  logic [9:0]  o_root_r, o_root_nxt;

  mul_req_t    mul_req;
  logic [23:0] prod_r;
  logic        fits;
  logic [3:0]  clu_per;
  logic [20:0] clu_half;
  logic [22:0] fat_bytes;
  logic [22:0] fat_round;
  logic        load;

  fat12_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  fat12_clu u_clu (
    .count         (count_r),
    .per_cluster   (clu_per),
    .half_clusters (clu_half)
  );

  // Every compare state checks the product that the multiplier just registered.
  assign fits = (prod_r <= {1'b0, limit_r});

  // FAT bytes are three per pair of clusters, rounded up to whole sectors.
  assign fat_bytes = {1'b0, half_r, 1'b0} + {2'b00, half_r};
  assign fat_round = fat_bytes + SECTOR_ROUND;

  assign in_stall = (state_r != ST_IDLE);
  assign load     = (state_r == ST_FAT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r      <= limit_nxt;
    small_root_r <= small_root_nxt;
    spt_r        <= spt_nxt;
    h_r          <= h_nxt;
    hsq_r        <= hsq_nxt;
    sq_r         <= sq_nxt;
    count_r      <= count_nxt;
    per_r        <= per_nxt;
    half_r       <= half_nxt;
    o_total_r    <= o_total_nxt;
    o_spt_r      <= o_spt_nxt;
    o_heads_r    <= o_heads_nxt;
    o_per_r      <= o_per_nxt;
    o_fat_r      <= o_fat_nxt;
    o_root_r     <= o_root_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    small_root_nxt = small_root_r;
    spt_nxt        = spt_r;
    h_nxt          = h_r;
    hsq_nxt        = hsq_r;
    sq_nxt         = sq_r;
    count_nxt      = count_r;
    per_nxt        = per_r;
    half_nxt       = half_r;
    o_total_nxt    = o_total_r;
    o_spt_nxt      = o_spt_r;
    o_heads_nxt    = o_heads_r;
    o_per_nxt      = o_per_r;
    o_fat_nxt      = o_fat_r;
    o_root_nxt     = o_root_r;
    mul_req        = '{a: 8'd0, b: 16'd0};
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        // Accept a beat and start squaring the next head count, which is two.
        if (in_valid) begin
          limit_nxt      = in_image_bytes[31:9];
          small_root_nxt = (in_image_bytes < LARGE_ROOT_BYTES);
          spt_nxt        = 8'd1;
          h_nxt          = 8'd1;
          hsq_nxt        = 16'd1;
          count_nxt      = 23'd1;
          mul_req        = '{a: 8'd2, b: 16'd2};
          state_nxt      = ST_M1;
        end
      end
      ST_M1: begin
        // The square of the next head count is ready; scale it by the track size.
        sq_nxt    = prod_r[15:0];
        mul_req   = '{a: spt_r, b: prod_r[15:0]};
        state_nxt = ST_C1;
      end
      ST_C1: begin
        // A head step that fits also bumps the track size; that bigger track
        // size stays even when its own product turns out too large.
        if (fits) begin
          h_nxt     = h_r + 8'd1;
          spt_nxt   = spt_r + 8'd1;
          hsq_nxt   = sq_r;
          count_nxt = prod_r[22:0];
          mul_req   = '{a: spt_r + 8'd1, b: sq_r};
          state_nxt = ST_C2;
        end else begin
          mul_req   = '{a: spt_r + 8'd1, b: hsq_r};
          state_nxt = ST_CF;
        end
      end
      ST_C2: begin
        if (fits) begin
          count_nxt = prod_r[22:0];
          mul_req   = '{a: h_r + 8'd1, b: {8'd0, h_r + 8'd1}};
          state_nxt = ST_M1;
        end else begin
          mul_req   = '{a: spt_r + 8'd1, b: hsq_r};
          state_nxt = ST_CF;
        end
      end
      ST_CF: begin
        // Last try: one more sector per track at the final head count.
        if (fits) begin
          spt_nxt   = spt_r + 8'd1;
          count_nxt = prod_r[22:0];
        end
        state_nxt = ST_CLU;
      end
      ST_CLU: begin
        per_nxt   = clu_per;
        half_nxt  = clu_half;
        state_nxt = ST_FAT;
      end
      ST_FAT: begin
        // Hold here while the previous result still waits to be taken.
        if (load) begin
          o_total_nxt   = count_r;
          o_spt_nxt     = spt_r;
          o_heads_nxt   = h_r;
          o_per_nxt     = per_r;
          o_fat_nxt     = fat_round[21:9];
          o_root_nxt    = small_root_r ? SMALL_ROOT_ENTRIES : LARGE_ROOT_ENTRIES;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_total_sectors    = o_total_r;
  assign out_track_sectors    = o_spt_r;
  assign out_head_count       = o_heads_r;
  assign out_cluster_sectors  = o_per_r;
  assign out_table_sectors    = o_fat_r;
  assign out_root_dir_entries = o_root_r;

  `FAT12_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_M1, "accept did not start search")
  `FAT12_ASSERT_NEXT(a_head_step, (state_r == ST_C1) && fits, h_r == $past(h_r) + 8'd1, "head step lost")
  `FAT12_ASSERT_NOW(a_cluster_code, out_valid, (out_cluster_sectors == CLUSTER_ONE) || (out_cluster_sectors == CLUSTER_FOUR) || (out_cluster_sectors == CLUSTER_EIGHT), "bad cluster size")
  `FAT12_ASSERT_NOW(a_geometry_nonzero, out_valid, (out_track_sectors != 8'd0) && (out_head_count != 8'd0), "zero geometry")

endmodule
`default_nettype wire
